### rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
label: assert property (@(posedge clk) disable iff (rst) (expr)) \
   else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/bpfa_pkg.sv
package bpfa_pkg;

   localparam int ADDR_W     = 48;
   localparam int COUNT_W    = 13;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_TOTAL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_COUNT = 2'd2;

   localparam logic [COUNT_W-1:0] PAGE_TOTAL_RESET = 13'd4096;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNALIGNED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 3'd5;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  pages_in_use;
      logic [COUNT_W-1:0]  free_pages;
   } rsp_type;

   typedef struct packed {
      logic clr_wr;
      logic req_load;
      logic scan_start;
      logic scan_next;
      logic free_diff;
      logic free_check;
      logic alloc_commit;
      logic alloc_oom;
      logic free_commit;
      logic addr_calc;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic req_mode;
      logic free_bad;
      logic alloc_hit;
      logic scan_last;
      logic free_here;
   } dp_sts_type;

endpackage

### rtl/bpfa_dp.sv
module bpfa_dp #(
   parameter int MAX_PAGES  = 4096,
   parameter int WORD_BITS  = 64,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bpfa_pkg::req_type                   req_data,
   output bpfa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  bpfa_pkg::dp_cmd_type                cmd,
   output bpfa_pkg::dp_sts_type                sts
);

   localparam int ADDR_W     = bpfa_pkg::ADDR_W;
   localparam int COUNT_W    = bpfa_pkg::COUNT_W;
   localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int FRAME_W    = $clog2(WORD_COUNT * WORD_BITS + 1);
   localparam int CMP_W      = (FRAME_W > COUNT_W + 1) ? FRAME_W : COUNT_W + 1;
   localparam int BIT_W      = $clog2(WORD_BITS);

   // configuration
   logic [ADDR_W-1:0]  region_base_ff, region_base_in;
   logic [COUNT_W-1:0] page_total_ff, page_total_in;
   logic [COUNT_W-1:0] reserved_count_ff, reserved_count_in;
   logic [COUNT_W-1:0] eff_total, eff_resv;

   // bitmap memory
   logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [WIDX_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [WIDX_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // control state
   logic [WIDX_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [COUNT_W-1:0] alloc_cnt_ff, alloc_cnt_in;

   // payload state
   bpfa_pkg::req_type             req_ff, req_in;
   logic [ADDR_W:0]               diff_ff, diff_in;
   logic [WIDX_W-1:0]             ptr_ff, ptr_in;
   logic [WIDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic [FRAME_W-1:0]            base_ff, base_in;
   logic [FRAME_W-1:0]            frame_ff, frame_in;
   logic [ADDR_W-1:0]             res_addr_ff, res_addr_in;
   logic [bpfa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   bpfa_pkg::rsp_type             rsp_ff, rsp_in;

   // datapath terms
   logic [CMP_W-1:0]     base_ext, next_base, total_ext, resv_ext, frame_ext;
   logic [WORD_BITS-1:0] avail;
   logic                 alloc_hit;
   logic [BIT_W-1:0]     alloc_bit;
   logic [BIT_W-1:0]     free_bit;
   logic                 free_set;
   logic [ADDR_W-1:0]    span;
   logic                 outside, unaligned, in_resv;
   logic [COUNT_W-1:0]   free_frame;
   logic [COUNT_W:0]     used_sum;
   logic [COUNT_W-1:0]   pages_in_use;

   assign eff_total = (32'(page_total_ff) > 32'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
                                                           : page_total_ff;
   assign eff_resv  = (reserved_count_ff > eff_total) ? eff_total : reserved_count_ff;

   assign base_ext  = CMP_W'(base_ff);
   assign next_base = base_ext + CMP_W'(WORD_BITS);
   assign total_ext = CMP_W'(eff_total);
   assign resv_ext  = CMP_W'(eff_resv);
   assign frame_ext = CMP_W'(frame_ff);

   always_comb begin
      logic [CMP_W-1:0] fj;
      fj        = '0;
      avail     = '0;
      alloc_hit = 1'b0;
      alloc_bit = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         fj       = base_ext + CMP_W'(j);
         avail[j] = !rd_data_ff[j] && (fj >= resv_ext) && (fj < total_ext);
      end
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            alloc_hit = 1'b1;
            alloc_bit = BIT_W'(j);
         end
      end
   end

   assign free_bit   = BIT_W'(frame_ext - base_ext);
   assign free_set   = rd_data_ff[free_bit];

   assign span       = ADDR_W'(eff_total) << PAGE_SHIFT;
   assign outside    = diff_ff[ADDR_W] || (diff_ff[ADDR_W-1:0] >= span);
   assign unaligned  = req_ff.free_address[PAGE_SHIFT-1:0] != '0;
   assign free_frame = diff_ff[PAGE_SHIFT +: COUNT_W];
   assign in_resv    = free_frame < eff_resv;

   assign used_sum     = (COUNT_W + 1)'(eff_resv) + (COUNT_W + 1)'(alloc_cnt_ff);
   assign pages_in_use = (used_sum > (COUNT_W + 1)'(eff_total)) ? eff_total
                                                               : used_sum[COUNT_W-1:0];

   assign sts.clr_done  = clr_ptr_ff == WIDX_W'(WORD_COUNT - 1);
   assign sts.req_mode  = req_ff.mode;
   assign sts.free_bad  = outside || unaligned || in_resv;
   assign sts.alloc_hit = alloc_hit;
   assign sts.scan_last = next_base >= total_ext;
   assign sts.free_here = frame_ext < next_base;

   // memory port control
   always_comb begin
      rd_en   = cmd.scan_start || cmd.scan_next;
      rd_addr = cmd.scan_start ? '0 : ptr_ff;
      wr_en   = 1'b0;
      wr_addr = chk_idx_ff;
      wr_data = rd_data_ff;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ptr_ff;
         wr_data = '0;
      end else if (cmd.alloc_commit) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff | (WORD_BITS'(1) << alloc_bit);
      end else if (cmd.free_commit && free_set) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff & ~(WORD_BITS'(1) << free_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   always_comb begin
      region_base_in    = region_base_ff;
      page_total_in     = page_total_ff;
      reserved_count_in = reserved_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bpfa_pkg::CSR_REGION_BASE:    region_base_in = csr_wr_data[ADDR_W-1:0];
            bpfa_pkg::CSR_PAGE_TOTAL:     page_total_in = csr_wr_data[COUNT_W-1:0];
            bpfa_pkg::CSR_RESERVED_COUNT: reserved_count_in = csr_wr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      clr_ptr_in    = cmd.clr_wr ? clr_ptr_ff + WIDX_W'(1) : clr_ptr_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      req_in        = cmd.req_load ? req_data : req_ff;
      diff_in       = diff_ff;
      ptr_in        = ptr_ff;
      chk_idx_in    = chk_idx_ff;
      base_in       = base_ff;
      frame_in      = frame_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;

      if (cmd.req_load) begin
         res_addr_in   = '0;
         res_status_in = bpfa_pkg::STATUS_OK;
      end
      if (cmd.free_diff) begin
         diff_in = {1'b0, req_ff.free_address} - {1'b0, region_base_ff};
      end
      if (rd_en) begin
         ptr_in     = rd_addr + WIDX_W'(1);
         chk_idx_in = rd_addr;
         base_in    = cmd.scan_start ? '0 : FRAME_W'(next_base);
      end
      if (cmd.free_check) begin
         priority if (outside) begin
            res_status_in = bpfa_pkg::STATUS_OUTSIDE;
         end else if (unaligned) begin
            res_status_in = bpfa_pkg::STATUS_UNALIGNED;
         end else if (in_resv) begin
            res_status_in = bpfa_pkg::STATUS_RESERVED;
         end else begin
            frame_in = FRAME_W'(CMP_W'(free_frame));
         end
      end
      if (cmd.alloc_commit) begin
         frame_in     = FRAME_W'(base_ext + CMP_W'(alloc_bit));
         alloc_cnt_in = alloc_cnt_ff + COUNT_W'(1);
      end
      if (cmd.alloc_oom) begin
         res_status_in = bpfa_pkg::STATUS_OOM;
      end
      if (cmd.free_commit) begin
         if (free_set) begin
            alloc_cnt_in = alloc_cnt_ff - COUNT_W'(1);
         end else begin
            res_status_in = bpfa_pkg::STATUS_NOT_ALLOC;
         end
      end
      if (cmd.addr_calc) begin
         res_addr_in = region_base_ff + (ADDR_W'(frame_ff) << PAGE_SHIFT);
      end
      if (cmd.out_load) begin
         rsp_in.page_address = res_addr_ff;
         rsp_in.status       = res_status_ff;
         rsp_in.pages_in_use = pages_in_use;
         rsp_in.free_pages   = eff_total - pages_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff    <= '0;
         page_total_ff     <= bpfa_pkg::PAGE_TOTAL_RESET;
         reserved_count_ff <= '0;
         clr_ptr_ff        <= '0;
         alloc_cnt_ff      <= '0;
      end else begin
         region_base_ff    <= region_base_in;
         page_total_ff     <= page_total_in;
         reserved_count_ff <= reserved_count_in;
         clr_ptr_ff        <= clr_ptr_in;
         alloc_cnt_ff      <= alloc_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      diff_ff       <= diff_in;
      ptr_ff        <= ptr_in;
      chk_idx_ff    <= chk_idx_in;
      base_ff       <= base_in;
      frame_ff      <= frame_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/bpfa_ctrl.sv
module bpfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bpfa_pkg::dp_sts_type sts,
   output bpfa_pkg::dp_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR      = 8'b0000_0001,
      ST_IDLE       = 8'b0000_0010,
      ST_START      = 8'b0000_0100,
      ST_FREE_CHECK = 8'b0000_1000,
      ST_ALLOC_SCAN = 8'b0001_0000,
      ST_FREE_SCAN  = 8'b0010_0000,
      ST_ALLOC_ADDR = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            if (sts.req_mode == bpfa_pkg::MODE_FREE) begin
               cmd.free_diff = 1'b1;
               state_in      = ST_FREE_CHECK;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_ALLOC_SCAN;
            end
         end
         ST_FREE_CHECK: begin
            cmd.free_check = 1'b1;
            if (sts.free_bad) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_FREE_SCAN;
            end
         end
         ST_ALLOC_SCAN: begin
            if (sts.alloc_hit) begin
               cmd.alloc_commit = 1'b1;
               state_in         = ST_ALLOC_ADDR;
            end else if (sts.scan_last) begin
               cmd.alloc_oom = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_FREE_SCAN: begin
            if (sts.free_here) begin
               cmd.free_commit = 1'b1;
               state_in        = ST_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_ALLOC_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/bitmap_page_frame_allocator_top.sv
// Allocate: start, then alloc scan of up to 64 bitmap words from word 0, then alloc addr,
// then finish; out of memory goes from alloc scan straight to finish.
// Free: start, check, scan up to the frame's word, finish; a rejected check skips the scan.
// One request in flight; next request taken the cycle after the result is registered.
// A new result waits in the finish state while the previous one is stalled.
// Reset (synchronous): clears the bitmap one word per cycle, requests stalled.
`include "assert_macros.svh"

module bitmap_page_frame_allocator_top #(
   parameter int MAX_PAGES  = 4096,
   parameter int WORD_BITS  = 64,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bpfa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bpfa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   bpfa_pkg::dp_cmd_type dp_cmd;
   bpfa_pkg::dp_sts_type dp_sts;

   bpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   bpfa_dp #(
      .MAX_PAGES  (MAX_PAGES),
      .WORD_BITS  (WORD_BITS),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (dp_cmd),
      .sts         (dp_sts)
   );

   `ASSERT_ALWAYS(a_out_no_overwrite, clock, reset, !(dp_cmd.out_load && rsp_valid && rsp_stall))
   `ASSERT_ALWAYS(a_one_mem_write, clock, reset, $onehot0({dp_cmd.clr_wr, dp_cmd.alloc_commit, dp_cmd.free_commit}))
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

endmodule

### tb/bitmap_page_frame_allocator_top_tb.sv
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_top_tb;

   localparam int MAX_FRAMES    = 4096;
   localparam int FRAME_SHIFT   = 12;
   localparam int ITEM_BUDGET   = 950;
   localparam int RANDOM_PHASES = 12;
   localparam int TAIL_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 600000;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   bpfa_pkg::req_type               req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   bpfa_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en   = 1'b0;
   logic [bpfa_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [bpfa_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   bit                           frame_used [MAX_FRAMES];
   logic [bpfa_pkg::COUNT_W-1:0] frames_out = '0;
   logic [bpfa_pkg::ADDR_W-1:0]  cfg_base   = '0;
   logic [bpfa_pkg::COUNT_W-1:0] cfg_total  = bpfa_pkg::PAGE_TOTAL_RESET;
   logic [bpfa_pkg::COUNT_W-1:0] cfg_resv   = '0;

   bpfa_pkg::req_type requests_todo [$];
   bpfa_pkg::rsp_type outcomes_due [$];
   int unsigned idle_pct = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bit          req_took = 1'b0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          queued = 0;
   int          settings_used = 0;
   int          tally [2][6];

   bitmap_page_frame_allocator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [bpfa_pkg::ADDR_W-1:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[bpfa_pkg::ADDR_W-1:0];
   endfunction

   function automatic int unsigned eff_total();
      return (cfg_total > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_total);
   endfunction

   function automatic int unsigned eff_resv();
      int unsigned total;
      total = eff_total();
      return (cfg_resv > total) ? total : int'(cfg_resv);
   endfunction

   function automatic logic [bpfa_pkg::ADDR_W-1:0] frame_addr(int unsigned f);
      return cfg_base + (48'(f) << FRAME_SHIFT);
   endfunction

   // advances the shadow bitmap by one transaction and returns its result
   function automatic bpfa_pkg::rsp_type frame_outcome(bpfa_pkg::req_type rq);
      bpfa_pkg::rsp_type res;
      int unsigned       total, resv, used, f;
      logic [63:0]       region_end;
      total = eff_total();
      resv  = eff_resv();
      res   = '0;
      res.status = bpfa_pkg::STATUS_OK;
      if (rq.mode == bpfa_pkg::MODE_ALLOC) begin
         f = resv;
         while (f < total && frame_used[f]) f++;
         if (f < total) begin
            frame_used[f] = 1'b1;
            frames_out = frames_out + 1'b1;
            res.page_address = frame_addr(f);
         end else begin
            res.status = bpfa_pkg::STATUS_OOM;
         end
      end else begin
         region_end = 64'(cfg_base) + (64'(total) << FRAME_SHIFT);
         if (64'(rq.free_address) < 64'(cfg_base) ||
             64'(rq.free_address) >= region_end) begin
            res.status = bpfa_pkg::STATUS_OUTSIDE;
         end else if (rq.free_address[FRAME_SHIFT-1:0] != '0) begin
            res.status = bpfa_pkg::STATUS_UNALIGNED;
         end else begin
            f = int'((rq.free_address - cfg_base) >> FRAME_SHIFT);
            if (f < resv) begin
               res.status = bpfa_pkg::STATUS_RESERVED;
            end else if (!frame_used[f]) begin
               res.status = bpfa_pkg::STATUS_NOT_ALLOC;
            end else begin
               frame_used[f] = 1'b0;
               frames_out = frames_out - 1'b1;
            end
         end
      end
      used = resv + frames_out;
      if (used > total) used = total;
      res.pages_in_use = used[bpfa_pkg::COUNT_W-1:0];
      res.free_pages   = bpfa_pkg::COUNT_W'(total - used);
      tally[rq.mode][res.status]++;
      return res;
   endfunction

   function automatic bit pick_used(int unsigned lo, int unsigned hi, output int unsigned fr);
      int unsigned span, start, i, f;
      fr = 0;
      if (hi <= lo) return 1'b0;
      span  = hi - lo;
      start = $urandom_range(span - 1, 0);
      for (i = 0; i < span; i++) begin
         f = lo + (start + i) % span;
         if (frame_used[f]) begin
            fr = f;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [bpfa_pkg::ADDR_W-1:0] noise_address(int unsigned total,
                                                                 int unsigned resv);
      logic [bpfa_pkg::ADDR_W-1:0] a;
      case ($urandom_range(6, 0))
         0: a = rand48();
         1: a = cfg_base - 48'($urandom_range(4096, 1));
         2: a = frame_addr(total + $urandom_range(3, 0));
         3: a = frame_addr((total == 0) ? 0 : $urandom_range(total - 1, 0))
                + 48'($urandom_range(4095, 1));
         4: a = (resv == 0) ? rand48() : frame_addr($urandom_range(resv - 1, 0));
         5: a = (total == 0) ? '0 : frame_addr($urandom_range(total - 1, 0));
         default: a = $urandom_range(1, 0) ? '1 : '0;
      endcase
      return a;
   endfunction

   task automatic queue_request(logic mode, logic [bpfa_pkg::ADDR_W-1:0] addr);
      bpfa_pkg::req_type rq;
      while (requests_todo.size() != 0) @(posedge clock);
      rq.mode = mode;
      rq.free_address = addr;
      requests_todo.push_back(rq);
      queued++;
   endtask

   // content is drawn from the shadow state after the previous transaction is handed over
   task automatic queue_random_request();
      int unsigned total, resv, r, fr;
      while (requests_todo.size() != 0) @(posedge clock);
      total = eff_total();
      resv  = eff_resv();
      r     = $urandom_range(99, 0);
      if (r < 45)
         queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      else if (r < 80 && pick_used(resv, total, fr))
         queue_request(bpfa_pkg::MODE_FREE, frame_addr(fr));
      else
         queue_request(bpfa_pkg::MODE_FREE, noise_address(total, resv));
   endtask

   task automatic set_region(logic [bpfa_pkg::ADDR_W-1:0] base,
                             logic [bpfa_pkg::COUNT_W-1:0] total,
                             logic [bpfa_pkg::COUNT_W-1:0] resv);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= bpfa_pkg::CSR_REGION_BASE;
      csr_wr_data <= base;
      @(negedge clock);
      csr_index   <= bpfa_pkg::CSR_PAGE_TOTAL;
      csr_wr_data <= {junk[34:0], total};
      @(negedge clock);
      csr_index   <= bpfa_pkg::CSR_RESERVED_COUNT;
      csr_wr_data <= {junk[63:29], resv};
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_base  = base;
      cfg_total = total;
      cfg_resv  = resv;
      settings_used++;
   endtask

   task automatic random_setting();
      logic [bpfa_pkg::ADDR_W-1:0]  base;
      logic [bpfa_pkg::COUNT_W-1:0] total, resv;
      case ($urandom_range(5, 0))
         0: base = '0;
         1: base = 48'hFFFF_FFFF_F000;
         2: base = 48'hFFFF_FFF8_0000;
         5: base = rand48();
         default: base = rand48() & ~48'hFFF;
      endcase
      case ($urandom_range(5, 0))
         0, 1: total = bpfa_pkg::COUNT_W'($urandom_range(64, 1));
         2: total = bpfa_pkg::COUNT_W'($urandom_range(600, 65));
         3: total = bpfa_pkg::COUNT_W'(MAX_FRAMES);
         4: total = bpfa_pkg::COUNT_W'($urandom_range(8191, 4097));
         default: total = bpfa_pkg::COUNT_W'($urandom_range(8191, 0));
      endcase
      case ($urandom_range(4, 0))
         0: resv = '0;
         1, 2: resv = bpfa_pkg::COUNT_W'($urandom_range((total > 64) ? 64 : total, 0));
         3: resv = (total > 8) ? bpfa_pkg::COUNT_W'($urandom_range(total, total - 8))
                               : total;
         default: resv = bpfa_pkg::COUNT_W'($urandom_range(8191, 0));
      endcase
      set_region(base, total, resv);
   endtask

   task automatic drain();
      while (requests_todo.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         outcomes_due.push_back(frame_outcome(req_data));
         req_took = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         req_took = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (requests_todo.size() != 0) begin
            if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
               send_gap = $urandom_range(15, 0);
               req_valid <= 1'b0;
            end else begin
               req_data  <= requests_todo.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         stall_left = $urandom_range(15, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      bpfa_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: result transaction with none outstanding: addr=%h status=%0d",
                        $time, rsp_data.page_address, rsp_data.status);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_data.page_address !== want.page_address ||
                rsp_data.status       !== want.status       ||
                rsp_data.pages_in_use !== want.pages_in_use ||
                rsp_data.free_pages   !== want.free_pages) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: mismatch want addr=%h st=%0d used=%0d free=%0d,",
                            " got addr=%h st=%0d used=%0d free=%0d"},
                           $time, want.page_address, want.status, want.pages_in_use,
                           want.free_pages, rsp_data.page_address, rsp_data.status,
                           rsp_data.pages_in_use, rsp_data.free_pages);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[bitmap_page_frame_allocator_top] ERROR");
         $finish;
      end
   end

   initial begin : main
      logic [bpfa_pkg::ADDR_W-1:0] base;
      int                          ph, n;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      idle_pct = 25;

      // reset values: base 0, 4096 pages, nothing reserved
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_FREE, 48'h1000);
      queue_request(bpfa_pkg::MODE_FREE, 48'h1000);
      queue_request(bpfa_pkg::MODE_FREE, 48'h0);
      queue_request(bpfa_pkg::MODE_FREE, 48'h100_0000);

      drain();
      base = 48'h1000_0000;
      set_region(base, 13'd8, 13'd2);
      repeat (6) queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_FREE, base - 48'h1000);
      queue_request(bpfa_pkg::MODE_FREE, base + 48'h8000);
      queue_request(bpfa_pkg::MODE_FREE, base + 48'h2010);
      queue_request(bpfa_pkg::MODE_FREE, base);
      queue_request(bpfa_pkg::MODE_FREE, base + 48'h1000);
      queue_request(bpfa_pkg::MODE_FREE, base + 48'h2000);
      queue_request(bpfa_pkg::MODE_FREE, base + 48'h2000);
      queue_request(bpfa_pkg::MODE_ALLOC, '1);

      drain();
      set_region('0, 13'd0, 13'd0);
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_FREE, '0);

      // reserved beyond total, total beyond the frame limit
      drain();
      set_region(48'hFFFF_FFFF_F000, 13'h1FFF, 13'h1FFF);
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());

      // addresses wrap past the top of the address space
      drain();
      set_region(48'hFFFF_FFFF_F000, 13'd16, 13'd0);
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_ALLOC, rand48());
      queue_request(bpfa_pkg::MODE_FREE, '0);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         if (ph == RANDOM_PHASES - 1) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(3, 0))
               0: idle_pct = 0;
               1: idle_pct = 10;
               2: idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         random_setting();
         n = (ITEM_BUDGET - queued) / (RANDOM_PHASES - ph);
         repeat (n) queue_random_request();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d transactions over %0d register settings; %0d pages granted, %0d out of memory.",
               queued, settings_used, tally[bpfa_pkg::MODE_ALLOC][bpfa_pkg::STATUS_OK],
               tally[bpfa_pkg::MODE_ALLOC][bpfa_pkg::STATUS_OOM]);
      $display({"Frees: %0d released, %0d outside, %0d unaligned, %0d reserved,",
                " %0d not allocated; %0d failures."},
               tally[bpfa_pkg::MODE_FREE][bpfa_pkg::STATUS_OK],
               tally[bpfa_pkg::MODE_FREE][bpfa_pkg::STATUS_OUTSIDE],
               tally[bpfa_pkg::MODE_FREE][bpfa_pkg::STATUS_UNALIGNED],
               tally[bpfa_pkg::MODE_FREE][bpfa_pkg::STATUS_RESERVED],
               tally[bpfa_pkg::MODE_FREE][bpfa_pkg::STATUS_NOT_ALLOC], fail_count);
      if (fail_count == 0 && outcomes_due.size() == 0) begin
         $display("[bitmap_page_frame_allocator_top] OK");
      end else begin
         $display("[bitmap_page_frame_allocator_top] ERROR");
      end
      $finish;
   end

endmodule
